FILE: rtl/core/nrmc_pkg.sv
`timescale 1ns / 1ps

package nrmc_pkg;

  // Widths of the time fields and of the parser counters.
  localparam int unsigned FieldW   = 7;
  localparam int unsigned PosW     = 6;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned NumDigit = 12;
  localparam int unsigned SlotW    = $clog2(NumDigit);

  // Sentence layout: the body is a fixed number of bytes after the identifier.
  localparam logic [PosW-1:0] BodyLast   = 6'd56;
  localparam logic [PosW-1:0] TimeLast   = 6'd6;
  localparam logic [PosW-1:0] SkipLast   = 6'd11;
  localparam logic [PosW-1:0] ValidPos   = 6'd12;
  localparam logic [PosW-1:0] Skip2Last  = 6'd49;
  localparam logic [PosW-1:0] DateComma  = 6'd50;
  localparam logic [PosW-1:0] DateOffset = 6'd45;
  localparam logic [PosW-1:0] IdLast     = 6'd4;
  localparam logic [PosW-1:0] IdLen      = 6'd5;

  // Characters of interest.
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // Counter tops.
  localparam logic [FieldW-1:0] TopCenti = 7'd99;
  localparam logic [FieldW-1:0] TopYear  = 7'd99;
  localparam logic [FieldW-1:0] TopSec   = 7'd59;
  localparam logic [FieldW-1:0] TopMin   = 7'd59;
  localparam logic [FieldW-1:0] TopHour  = 7'd23;
  localparam logic [FieldW-1:0] LastMon  = 7'd12;

  // Item kinds carried in the input tuser bit.
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Parser phases, one-hot.
  typedef enum logic [3:0] {
    PH_SEEK = 4'b0001,
    PH_ID   = 4'b0010,
    PH_BODY = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  // Time values handed from the parser when a sentence passes.
  typedef struct packed {
    logic              valid;
    logic [FieldW-1:0] year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
  } load_t;

  // Full calendar clock state.
  typedef struct packed {
    logic [FieldW-1:0] year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
    logic [FieldW-1:0] centi;
    logic              loaded;
  } cal_t;

  // Identifier characters following the dollar sign.
  function automatic logic [7:0] id_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h47; // G
      3'd1:    c = 8'h50; // P
      3'd2:    c = 8'h52; // R
      3'd3:    c = 8'h4D; // M
      3'd4:    c = 8'h43; // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Two decimal digits to a binary value.
  function automatic logic [FieldW-1:0] pair_value(input logic [DigitW-1:0] hi,
                                                   input logic [DigitW-1:0] lo);
    logic [FieldW-1:0] v;
    v = {3'b000, hi} * 7'd10 + {3'b000, lo};
    return v;
  endfunction

  // Length of a month; zero marks a month out of range.
  function automatic logic [4:0] month_len(input logic [FieldW-1:0] mon);
    logic [4:0] len;
    case (mon)
      7'd2:                                       len = 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/nrmc_parser.sv
`timescale 1ns / 1ps

module nrmc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [7:0]          byte_i,
  output nrmc_pkg::load_t     load_o
);

  nrmc_pkg::phase_e                   phase_q, phase_d;
  logic [nrmc_pkg::PosW-1:0]          pos_q, pos_d;
  logic                               bad_q, bad_d;
  logic [nrmc_pkg::DigitW-1:0]        digits_q [nrmc_pkg::NumDigit];
  logic [nrmc_pkg::DigitW-1:0]        digits_d [nrmc_pkg::NumDigit];
  logic                               is_digit;
  logic [nrmc_pkg::PosW-1:0]          slot_wide;
  logic [nrmc_pkg::SlotW-1:0]         slot;
  logic                               capture;

  assign is_digit = (byte_i >= nrmc_pkg::ChZero) && (byte_i <= nrmc_pkg::ChNine);

  // Digit slot: time digits follow the first comma, date digits the second.
  always_comb begin
    if (pos_q <= nrmc_pkg::TimeLast) begin
      slot_wide = pos_q - 6'd1;
    end else begin
      slot_wide = pos_q - nrmc_pkg::DateOffset;
    end
    slot = slot_wide[nrmc_pkg::SlotW-1:0];
  end

  // Next parser state for one received byte.
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    bad_d    = bad_q;
    digits_d = digits_q;
    capture  = 1'b0;
    load_o   = '0;
    unique case (phase_q)
      nrmc_pkg::PH_SEEK: begin
        bad_d = 1'b0;
        pos_d = '0;
        if (byte_i == nrmc_pkg::ChDollar) begin
          phase_d = nrmc_pkg::PH_ID;
        end
      end
      nrmc_pkg::PH_ID: begin
        if (pos_q < nrmc_pkg::IdLen && byte_i == nrmc_pkg::id_char(pos_q[2:0])) begin
          if (pos_q == nrmc_pkg::IdLast) begin
            phase_d = nrmc_pkg::PH_BODY;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 6'd1;
          end
        end else begin
          phase_d = nrmc_pkg::PH_SEEK;
          pos_d   = '0;
        end
      end
      nrmc_pkg::PH_BODY: begin
        if (pos_q == '0) begin
          if (byte_i != nrmc_pkg::ChComma) bad_d = 1'b1;
        end else if (pos_q <= nrmc_pkg::TimeLast) begin
          capture = 1'b1;
        end else if (pos_q <= nrmc_pkg::SkipLast) begin
          bad_d = bad_q;
        end else if (pos_q == nrmc_pkg::ValidPos) begin
          if (byte_i != nrmc_pkg::ChA) bad_d = 1'b1;
        end else if (pos_q <= nrmc_pkg::Skip2Last) begin
          bad_d = bad_q;
        end else if (pos_q == nrmc_pkg::DateComma) begin
          if (byte_i != nrmc_pkg::ChComma) bad_d = 1'b1;
        end else begin
          capture = 1'b1;
        end
        if (capture) begin
          if (is_digit) begin
            digits_d[slot] = byte_i[3:0];
          end else begin
            bad_d = 1'b1;
          end
        end
        // End of body: load the time or start looking again.
        if (pos_q >= nrmc_pkg::BodyLast) begin
          pos_d = '0;
          if (bad_d) begin
            phase_d = nrmc_pkg::PH_SEEK;
          end else begin
            phase_d       = nrmc_pkg::PH_DONE;
            load_o.valid  = en_i;
            load_o.hour   = nrmc_pkg::pair_value(digits_d[0], digits_d[1]);
            load_o.minute = nrmc_pkg::pair_value(digits_d[2], digits_d[3]);
            load_o.second = nrmc_pkg::pair_value(digits_d[4], digits_d[5]);
            load_o.day    = nrmc_pkg::pair_value(digits_d[6], digits_d[7]);
            load_o.month  = nrmc_pkg::pair_value(digits_d[8], digits_d[9]);
            load_o.year   = nrmc_pkg::pair_value(digits_d[10], digits_d[11]);
          end
        end else begin
          pos_d = pos_q + 6'd1;
        end
      end
      nrmc_pkg::PH_DONE: begin
        phase_d = nrmc_pkg::PH_DONE;
      end
      default: begin
        phase_d = nrmc_pkg::PH_SEEK;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nrmc_pkg::PH_SEEK;
      pos_q   <= '0;
      bad_q   <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      bad_q   <= bad_d;
    end
  end

  // Captured digits are always written before they are read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      digits_q <= digits_d;
    end
  end

endmodule

FILE: rtl/core/nrmc_clock.sv
`timescale 1ns / 1ps

module nrmc_clock (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            tick_i,
  input  nrmc_pkg::load_t load_i,
  output nrmc_pkg::cal_t  cal_o
);

  nrmc_pkg::cal_t cal_q, cal_d;
  logic [4:0]     len;

  assign len = nrmc_pkg::month_len(cal_q.month);

  // Ripple of the tick through the calendar fields, or a load from the parser.
  always_comb begin
    cal_d = cal_q;
    if (tick_i) begin
      if (cal_q.centi < nrmc_pkg::TopCenti) begin
        cal_d.centi = cal_q.centi + 7'd1;
      end else begin
        cal_d.centi = '0;
        if (cal_q.second < nrmc_pkg::TopSec) begin
          cal_d.second = cal_q.second + 7'd1;
        end else begin
          cal_d.second = '0;
          if (cal_q.minute < nrmc_pkg::TopMin) begin
            cal_d.minute = cal_q.minute + 7'd1;
          end else begin
            cal_d.minute = '0;
            if (cal_q.hour < nrmc_pkg::TopHour) begin
              cal_d.hour = cal_q.hour + 7'd1;
            end else begin
              cal_d.hour = '0;
              // A month out of range leaves day and month as they are.
              if (len != 5'd0) begin
                if (cal_q.day >= {2'b00, len}) begin
                  cal_d.day = 7'd1;
                  if (cal_q.month >= nrmc_pkg::LastMon) begin
                    cal_d.month = 7'd1;
                    cal_d.year  = (cal_q.year >= nrmc_pkg::TopYear) ? '0 : cal_q.year + 7'd1;
                  end else begin
                    cal_d.month = cal_q.month + 7'd1;
                  end
                end else begin
                  cal_d.day = cal_q.day + 7'd1;
                end
              end
            end
          end
        end
      end
    end else if (load_i.valid) begin
      cal_d.year   = load_i.year;
      cal_d.month  = load_i.month;
      cal_d.day    = load_i.day;
      cal_d.hour   = load_i.hour;
      cal_d.minute = load_i.minute;
      cal_d.second = load_i.second;
      cal_d.loaded = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (en_i) begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_d;

endmodule

FILE: rtl/core/nmea_rmc_time_loader_calendar_clock.sv
`timescale 1ns / 1ps
// A word accepted into the input register is processed when it advances, which
// also loads its result into the result register on the master side.
// Throughput: one word per cycle while m_axis_tready holds, set by the single pass
// through the parser and the calendar update between the input and result registers.
// Reset (asynchronous, active low) empties both stages, zeroes the clock and
// puts the parser back to looking for the dollar sign.
module nmea_rmc_time_loader_calendar_clock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // year, month, day, hour, minute, second,
                                      // centisecond (7 bits each), time_loaded, zero pad
);

  logic            in_valid_q;
  logic            in_cmd_q;
  logic [7:0]      in_byte_q;
  logic            out_valid_q;
  logic [55:0]     out_data_q;
  logic            advance;
  nrmc_pkg::load_t load;
  nrmc_pkg::cal_t  cal;

  // The held word moves on whenever the result register is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  nrmc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance && (in_cmd_q == nrmc_pkg::CmdByte)),
    .byte_i (in_byte_q),
    .load_o (load)
  );

  nrmc_clock u_clock (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .tick_i (in_cmd_q == nrmc_pkg::CmdTick),
    .load_i (load),
    .cal_o  (cal)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'b000000, cal.loaded, cal.centi, cal.second, cal.minute,
                     cal.hour, cal.day, cal.month, cal.year};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
